// ----- rtl/core/mips64_integer_execute_unit_assert.svh -----
// assertion macros for the integer execute unit
`ifndef MIPS64_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS64_INTEGER_EXECUTE_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MIE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/mie_pkg.sv -----
// shared types and constants of the integer execute unit
`default_nettype none
package mie_pkg;
  localparam int unsigned XLEN = 64;

  typedef enum logic [4:0] {
    ALU_NONE  = 5'd0,
    ALU_SLL   = 5'd1,
    ALU_SRL   = 5'd2,
    ALU_SRA   = 5'd3,
    ALU_ADD32 = 5'd4,
    ALU_SUB32 = 5'd5,
    ALU_AND   = 5'd6,
    ALU_OR    = 5'd7,
    ALU_XOR   = 5'd8,
    ALU_NOR   = 5'd9,
    ALU_SLT   = 5'd10,
    ALU_SLTU  = 5'd11,
    ALU_ADD64 = 5'd12,
    ALU_SUB64 = 5'd13,
    ALU_DSLL  = 5'd14,
    ALU_DSRL  = 5'd15,
    ALU_DSRA  = 5'd16,
    ALU_MOVZ  = 5'd17,
    ALU_MOVN  = 5'd18,
    ALU_MFSA  = 5'd19,
    ALU_MTSA  = 5'd20,
    ALU_MFHI  = 5'd21,
    ALU_MTHI  = 5'd22,
    ALU_MFLO  = 5'd23,
    ALU_MTLO  = 5'd24,
    ALU_MULT  = 5'd25,
    ALU_MULTU = 5'd26,
    ALU_DIV   = 5'd27,
    ALU_DIVU  = 5'd28,
    ALU_LUI   = 5'd29
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic        bad;
    logic        b_imm;
    logic        imm_sx;
    logic        dst_rt;
    logic [5:0]  shamt;
    logic        shamt_var;
    logic        sh32;
  } dec_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_reg;
    logic exec;
    logic mul_lo;
    logic mul_hi;
    logic div_start;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_done;
  } dp_sts_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/mie_if.sv -----
// valid/ready channel carrying a generic payload
`default_nettype none
interface mie_stream_if #(parameter int unsigned W = 32) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mie_ctrl.sv -----
// sequencer of the integer execute unit
`default_nettype none
module mie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mie_pkg::dp_sts_t  sts,
  output mie_pkg::dp_cmd_t  cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MULH = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_MULP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_reg = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_mul) begin
          cmd.mul_lo = 1'b1;
          state_nxt = S_MULP;
        end else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.exec = 1'b1;
          state_nxt = S_OUT;
        end
      end
      // product register loads from the operand magnitudes
      S_MULP: begin
        state_nxt = S_MULH;
      end
      S_MULH: begin
        cmd.mul_hi = 1'b1;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

`include "mips64_integer_execute_unit_assert.svh"
  `MIE_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `MIE_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(in_ready && out_valid))
  `MIE_ASSERT_NXT(a_cap, clk, rst_n, in_valid && in_ready, state_r == S_READ)
endmodule
`default_nettype wire

// ----- rtl/core/mie_dpath.sv -----
// register file, alu, multiplier and divider of the integer execute unit
`default_nettype none
module mie_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       instr_word,
  input  mie_pkg::dp_cmd_t  cmd,
  output mie_pkg::dp_sts_t  sts,
  output logic              status,
  output logic              gpr_written,
  output logic [4:0]        dest_index,
  output logic [63:0]       dest_value,
  output logic [63:0]       hi_value,
  output logic [63:0]       lo_value
);
  logic [63:0] gpr_mem [32];
  logic [31:0] gpr_vld_r;
  logic [31:0] ir_r;
  mie_pkg::dec_t dec_r, dec_nxt;
  logic [63:0] a_raw_r, b_raw_r;
  logic [63:0] a_v, b_v;
  logic [63:0] hi_r, lo_r;
  logic [31:0] sar_r;
  logic        wr_r;
  logic [4:0]  widx_r;
  logic [63:0] wval_r;
  logic        bad_r;
  logic [63:0] prod_r;
  logic [31:0] ma_r, mb_r;
  logic        msign_r;

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sa;
  assign op = ir_r[31:26];
  assign rs = ir_r[25:21];
  assign rt = ir_r[20:16];
  assign rd = ir_r[15:11];
  assign sa = ir_r[10:6];
  assign fn = ir_r[5:0];

  always_comb begin
    dec_nxt = '0;
    dec_nxt.op = mie_pkg::ALU_NONE;
    unique case (op)
      6'h00: begin
        unique case (fn)
          6'h00: begin dec_nxt.op = mie_pkg::ALU_SLL; dec_nxt.sh32 = 1'b1; end
          6'h02: begin dec_nxt.op = mie_pkg::ALU_SRL; dec_nxt.sh32 = 1'b1; end
          6'h03: begin dec_nxt.op = mie_pkg::ALU_SRA; dec_nxt.sh32 = 1'b1; end
          6'h04: begin dec_nxt.op = mie_pkg::ALU_SLL; dec_nxt.shamt_var = 1'b1; end
          6'h06: begin dec_nxt.op = mie_pkg::ALU_SRL; dec_nxt.shamt_var = 1'b1; end
          6'h07: begin dec_nxt.op = mie_pkg::ALU_SRA; dec_nxt.shamt_var = 1'b1; end
          6'h0a: dec_nxt.op = mie_pkg::ALU_MOVZ;
          6'h0b: dec_nxt.op = mie_pkg::ALU_MOVN;
          6'h0f, 6'h30, 6'h31, 6'h32, 6'h33, 6'h34, 6'h36: dec_nxt.op = mie_pkg::ALU_NONE;
          6'h28: dec_nxt.op = mie_pkg::ALU_MFSA;
          6'h29: dec_nxt.op = mie_pkg::ALU_MTSA;
          6'h10: dec_nxt.op = mie_pkg::ALU_MFHI;
          6'h11: dec_nxt.op = mie_pkg::ALU_MTHI;
          6'h12: dec_nxt.op = mie_pkg::ALU_MFLO;
          6'h13: dec_nxt.op = mie_pkg::ALU_MTLO;
          6'h14: begin dec_nxt.op = mie_pkg::ALU_DSLL; dec_nxt.shamt_var = 1'b1; end
          6'h16: begin dec_nxt.op = mie_pkg::ALU_DSRL; dec_nxt.shamt_var = 1'b1; end
          6'h17: begin dec_nxt.op = mie_pkg::ALU_DSRA; dec_nxt.shamt_var = 1'b1; end
          6'h18: dec_nxt.op = mie_pkg::ALU_MULT;
          6'h19: dec_nxt.op = mie_pkg::ALU_MULTU;
          6'h1a: dec_nxt.op = mie_pkg::ALU_DIV;
          6'h1b: dec_nxt.op = mie_pkg::ALU_DIVU;
          6'h20, 6'h21: dec_nxt.op = mie_pkg::ALU_ADD32;
          6'h22, 6'h23: dec_nxt.op = mie_pkg::ALU_SUB32;
          6'h24: dec_nxt.op = mie_pkg::ALU_AND;
          6'h25: dec_nxt.op = mie_pkg::ALU_OR;
          6'h26: dec_nxt.op = mie_pkg::ALU_XOR;
          6'h27: dec_nxt.op = mie_pkg::ALU_NOR;
          6'h2a: dec_nxt.op = mie_pkg::ALU_SLT;
          6'h2b: dec_nxt.op = mie_pkg::ALU_SLTU;
          6'h2c, 6'h2d: dec_nxt.op = mie_pkg::ALU_ADD64;
          6'h2e, 6'h2f: dec_nxt.op = mie_pkg::ALU_SUB64;
          6'h38: begin dec_nxt.op = mie_pkg::ALU_DSLL; dec_nxt.shamt = {1'b0, sa}; end
          6'h3a: begin dec_nxt.op = mie_pkg::ALU_DSRL; dec_nxt.shamt = {1'b0, sa}; end
          6'h3b: begin dec_nxt.op = mie_pkg::ALU_DSRA; dec_nxt.shamt = {1'b0, sa}; end
          6'h3c: begin dec_nxt.op = mie_pkg::ALU_DSLL; dec_nxt.shamt = {1'b1, sa}; end
          6'h3e: begin dec_nxt.op = mie_pkg::ALU_DSRL; dec_nxt.shamt = {1'b1, sa}; end
          6'h3f: begin dec_nxt.op = mie_pkg::ALU_DSRA; dec_nxt.shamt = {1'b1, sa}; end
          default: dec_nxt.bad = 1'b1;
        endcase
        if (dec_nxt.sh32) dec_nxt.shamt = {1'b0, sa};
      end
      6'h08, 6'h09: begin
        dec_nxt.op = mie_pkg::ALU_ADD32; dec_nxt.b_imm = 1'b1;
        dec_nxt.imm_sx = 1'b1; dec_nxt.dst_rt = 1'b1;
      end
      6'h0a: begin
        dec_nxt.op = mie_pkg::ALU_SLT; dec_nxt.b_imm = 1'b1;
        dec_nxt.imm_sx = 1'b1; dec_nxt.dst_rt = 1'b1;
      end
      6'h0b: begin
        dec_nxt.op = mie_pkg::ALU_SLTU; dec_nxt.b_imm = 1'b1;
        dec_nxt.imm_sx = 1'b1; dec_nxt.dst_rt = 1'b1;
      end
      6'h0c: begin dec_nxt.op = mie_pkg::ALU_AND; dec_nxt.b_imm = 1'b1; dec_nxt.dst_rt = 1'b1; end
      6'h0d: begin dec_nxt.op = mie_pkg::ALU_OR; dec_nxt.b_imm = 1'b1; dec_nxt.dst_rt = 1'b1; end
      6'h0e: begin dec_nxt.op = mie_pkg::ALU_XOR; dec_nxt.b_imm = 1'b1; dec_nxt.dst_rt = 1'b1; end
      6'h0f: begin dec_nxt.op = mie_pkg::ALU_LUI; dec_nxt.dst_rt = 1'b1; end
      6'h18, 6'h19: begin
        dec_nxt.op = mie_pkg::ALU_ADD64; dec_nxt.b_imm = 1'b1;
        dec_nxt.imm_sx = 1'b1; dec_nxt.dst_rt = 1'b1;
      end
      6'h2f, 6'h33: dec_nxt.op = mie_pkg::ALU_NONE;
      default: dec_nxt.bad = 1'b1;
    endcase
  end

  // register file read, registered
  always_ff @(posedge clk) begin
    if (cmd.capture) ir_r <= instr_word;
    if (cmd.rd_reg) begin
      a_raw_r <= gpr_mem[rs];
      b_raw_r <= gpr_mem[rt];
      dec_r <= dec_nxt;
    end
  end

  logic rd_va_r, rd_vb_r;
  always_ff @(posedge clk) begin
    if (cmd.rd_reg) begin
      rd_va_r <= gpr_vld_r[rs] && (rs != 5'd0);
      rd_vb_r <= gpr_vld_r[rt] && (rt != 5'd0);
    end
  end

  assign a_v = rd_va_r ? a_raw_r : 64'd0;
  logic [63:0] rt_v;
  assign rt_v = rd_vb_r ? b_raw_r : 64'd0;
  logic [63:0] imm_v;
  assign imm_v = dec_r.imm_sx ? {{48{ir_r[15]}}, ir_r[15:0]} : {48'd0, ir_r[15:0]};
  assign b_v = dec_r.b_imm ? imm_v : rt_v;

  logic [5:0] sh;
  assign sh = dec_r.shamt_var ? a_v[5:0] : dec_r.shamt;
  logic [4:0] sh5;
  assign sh5 = sh[4:0];

  logic [63:0] res;
  logic        do_wr;
  always_comb begin
    res = '0;
    do_wr = 1'b1;
    unique case (dec_r.op)
      mie_pkg::ALU_SLL:   res = mie_pkg::sx32(b_v[31:0] << sh5);
      mie_pkg::ALU_SRL:   res = mie_pkg::sx32(b_v[31:0] >> sh5);
      mie_pkg::ALU_SRA:   res = mie_pkg::sx32(32'($signed(b_v[31:0]) >>> sh5));
      mie_pkg::ALU_ADD32: res = mie_pkg::sx32(a_v[31:0] + b_v[31:0]);
      mie_pkg::ALU_SUB32: res = mie_pkg::sx32(a_v[31:0] - b_v[31:0]);
      mie_pkg::ALU_AND:   res = a_v & b_v;
      mie_pkg::ALU_OR:    res = a_v | b_v;
      mie_pkg::ALU_XOR:   res = a_v ^ b_v;
      mie_pkg::ALU_NOR:   res = ~(a_v | b_v);
      mie_pkg::ALU_SLT:   res = {63'd0, $signed(a_v) < $signed(b_v)};
      mie_pkg::ALU_SLTU:  res = {63'd0, a_v < b_v};
      mie_pkg::ALU_ADD64: res = a_v + b_v;
      mie_pkg::ALU_SUB64: res = a_v - b_v;
      mie_pkg::ALU_DSLL:  res = b_v << sh;
      mie_pkg::ALU_DSRL:  res = b_v >> sh;
      mie_pkg::ALU_DSRA:  res = 64'($signed(b_v) >>> sh);
      mie_pkg::ALU_MOVZ:  begin res = a_v; do_wr = (b_v == 64'd0); end
      mie_pkg::ALU_MOVN:  begin res = a_v; do_wr = (b_v != 64'd0); end
      mie_pkg::ALU_MFSA:  res = {32'd0, sar_r};
      mie_pkg::ALU_MFHI:  res = hi_r;
      mie_pkg::ALU_MFLO:  res = lo_r;
      mie_pkg::ALU_LUI:   res = mie_pkg::sx32({ir_r[15:0], 16'd0});
      default:            do_wr = 1'b0;
    endcase
    if (dec_r.bad) do_wr = 1'b0;
  end

  logic [4:0] dst;
  assign dst = dec_r.dst_rt ? rt : rd;

  assign sts.is_mul = !dec_r.bad &&
    (dec_r.op == mie_pkg::ALU_MULT || dec_r.op == mie_pkg::ALU_MULTU);
  assign sts.is_div = !dec_r.bad &&
    (dec_r.op == mie_pkg::ALU_DIV || dec_r.op == mie_pkg::ALU_DIVU);

  // multiplier: magnitudes registered, product registered, sign fix next
  logic [63:0] prod_s;
  assign prod_s = msign_r ? (~prod_r + 64'd1) : prod_r;

  // restoring divider, one quotient bit per cycle
  logic [31:0] dq_r, dr_r, dd_r;
  logic [32:0] rem_r;
  logic [5:0]  dcnt_r;
  logic        dbusy_r, qneg_r, rneg_r, dsgn_r;
  logic [32:0] trial;
  assign trial = {rem_r[31:0], dq_r[31]} - {1'b0, dr_r};
  assign sts.div_done = dbusy_r && (dcnt_r == 6'd32);

  logic [31:0] ua, ub;
  assign ua = a_v[31:0];
  assign ub = b_v[31:0];

  logic [31:0] qf, rf;
  assign qf = qneg_r ? (~dq_r + 32'd1) : dq_r;
  assign rf = rneg_r ? (~rem_r[31:0] + 32'd1) : rem_r[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      ma_r <= (dec_r.op == mie_pkg::ALU_MULT && ua[31]) ? (~ua + 32'd1) : ua;
      mb_r <= (dec_r.op == mie_pkg::ALU_MULT && ub[31]) ? (~ub + 32'd1) : ub;
      msign_r <= (dec_r.op == mie_pkg::ALU_MULT) && (ua[31] ^ ub[31]);
    end
    prod_r <= {32'd0, ma_r} * {32'd0, mb_r};
    if (cmd.div_start) begin
      dsgn_r <= (dec_r.op == mie_pkg::ALU_DIV);
      dd_r <= ua;
      dr_r <= (dec_r.op == mie_pkg::ALU_DIV && ub[31]) ? (~ub + 32'd1) : ub;
      dq_r <= (dec_r.op == mie_pkg::ALU_DIV && ua[31]) ? (~ua + 32'd1) : ua;
      qneg_r <= (dec_r.op == mie_pkg::ALU_DIV) && (ua[31] ^ ub[31]);
      rneg_r <= (dec_r.op == mie_pkg::ALU_DIV) && ua[31];
      rem_r <= '0;
      dcnt_r <= '0;
    end else if (dbusy_r && dcnt_r != 6'd32) begin
      if (!trial[32]) begin
        rem_r <= trial;
        dq_r <= {dq_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], dq_r[31]};
        dq_r <= {dq_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dbusy_r <= 1'b0;
    else if (cmd.div_start) dbusy_r <= 1'b1;
    else if (cmd.finish) dbusy_r <= 1'b0;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
      sar_r <= '0;
      gpr_vld_r <= '0;
      wr_r <= 1'b0;
      widx_r <= '0;
      wval_r <= '0;
      bad_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        bad_r <= dec_r.bad;
        wr_r <= do_wr && (dst != 5'd0);
        widx_r <= (do_wr && dst != 5'd0) ? dst : 5'd0;
        wval_r <= (do_wr && dst != 5'd0) ? res : 64'd0;
        if (do_wr && dst != 5'd0) gpr_vld_r[dst] <= 1'b1;
        if (!dec_r.bad) begin
          if (dec_r.op == mie_pkg::ALU_MTSA) sar_r <= a_v[31:0];
          if (dec_r.op == mie_pkg::ALU_MTHI) hi_r <= a_v;
          if (dec_r.op == mie_pkg::ALU_MTLO) lo_r <= a_v;
        end
      end
      if (cmd.mul_lo) bad_r <= 1'b0;
      if (cmd.mul_hi) begin
        lo_r <= mie_pkg::sx32(prod_s[31:0]);
        hi_r <= mie_pkg::sx32(prod_s[63:32]);
        wr_r <= (rd != 5'd0);
        widx_r <= rd;
        wval_r <= (rd != 5'd0) ? mie_pkg::sx32(prod_s[31:0]) : 64'd0;
        if (rd != 5'd0) gpr_vld_r[rd] <= 1'b1;
      end
      if (cmd.div_start) begin
        bad_r <= 1'b0;
        wr_r <= 1'b0;
        widx_r <= '0;
        wval_r <= '0;
      end
      if (cmd.finish) begin
        if (ub == 32'd0) begin
          lo_r <= (dsgn_r && dd_r[31]) ? 64'd1 : {64{1'b1}};
          hi_r <= mie_pkg::sx32(dd_r);
        end else if (dsgn_r && dd_r == 32'h8000_0000 && ub == 32'hffff_ffff) begin
          lo_r <= mie_pkg::sx32(32'h8000_0000);
          hi_r <= '0;
        end else begin
          lo_r <= mie_pkg::sx32(qf);
          hi_r <= mie_pkg::sx32(rf);
        end
      end
    end
  end

  logic        gw;
  logic [4:0]  gi;
  logic [63:0] gv;
  always_comb begin
    gw = 1'b0;
    gi = dst;
    gv = res;
    if (cmd.exec) gw = do_wr && (dst != 5'd0);
    if (cmd.mul_hi) begin
      gw = (rd != 5'd0);
      gi = rd;
      gv = mie_pkg::sx32(prod_s[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (gw) gpr_mem[gi] <= gv;
  end

  assign status = bad_r;
  assign gpr_written = wr_r;
  assign dest_index = widx_r;
  assign dest_value = wval_r;
  assign hi_value = hi_r;
  assign lo_value = lo_r;

`include "mips64_integer_execute_unit_assert.svh"
  `MIE_ASSERT_IMP(a_nowr0, clk, rst_n, 1'b1, !(gw && gi == 5'd0))
  `MIE_ASSERT_IMP(a_wrzero, clk, rst_n, !wr_r, widx_r == 5'd0 && wval_r == 64'd0)
  `MIE_ASSERT_NXT(a_divgo, clk, rst_n, cmd.div_start, dbusy_r && dcnt_r == 6'd0)
endmodule
`default_nettype wire

// ----- rtl/core/mips64_integer_execute_unit.sv -----
// top level of the 64-bit integer execute unit
// in channel: one 32-bit instruction word per item, valid/ready handshake.
// out channel: one result item per instruction: status, gpr_written,
// dest_index, dest_value, hi_value and lo_value.
// the unit takes one instruction at a time: capture, register file read,
// execute, then the result sits in the output register until taken.
// mult/multu also pass through the operand magnitudes, a registered 32x32
// product and a sign fix; div/divu pass through a restoring divider
// (one quotient bit per cycle).
// in_ready is high only while the unit is empty; a new instruction is taken
// the cycle after its result is accepted.
// reset clears hi, lo, the shift-amount register and the register file valid
// bits, so every general register reads zero afterwards.
// while out_ready is low the result holds and no new item is accepted.
`default_nettype none
module mips64_integer_execute_unit (
  input  logic           clk,
  input  logic           rst_n,
  mie_stream_if.sink     in_ch,
  mie_stream_if.source   out_ch
);
  mie_pkg::dp_cmd_t cmd;
  mie_pkg::dp_sts_t sts;
  logic        status, gpr_written;
  logic [4:0]  dest_index;
  logic [63:0] dest_value, hi_value, lo_value;

  mie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  mie_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .instr_word(in_ch.data),
    .cmd(cmd), .sts(sts),
    .status(status), .gpr_written(gpr_written), .dest_index(dest_index),
    .dest_value(dest_value), .hi_value(hi_value), .lo_value(lo_value)
  );

  assign out_ch.data = {status, gpr_written, dest_index, dest_value, hi_value, lo_value};
endmodule
`default_nettype wire
